// ===== hdl/wpt_pkg.sv =====
// Waypoint path tracker package: record layout, sequencer states, codes, CORDIC constants.
// No dependencies; imported by waypoint_path_tracker_unit and its testbench.
`default_nettype none
package wpt_pkg;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] heading;
    logic signed [31:0] curvature;
    logic signed [31:0] speed;
    logic        [31:0] arc;
  } waypoint_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LD_SQ,
    ST_LD_WAIT,
    ST_LD_ROOT,
    ST_LD_WR,
    ST_SRCH,
    ST_DRAIN,
    ST_RD_BEST,
    ST_CTE_CAP,
    ST_CORDIC,
    ST_MUL,
    ST_CTE_SUM,
    ST_LA_RD,
    ST_LA_CMP,
    ST_RD_LOOK,
    ST_OUT,
    ST_EMPTY
  } wpt_state_e;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_TRACK = 1'b1
  } wpt_cmd_e;

  localparam logic [2:0] REG_LOOKAHEAD = 3'd0;
  localparam logic [2:0] REG_DONE_THR  = 3'd4;

  localparam logic [31:0] LOOKAHEAD_RST = 32'd327680;
  localparam logic [31:0] DONE_THR_RST  = 32'd65536;

  localparam logic signed [16:0] Q12_PI      = 17'sd12868;
  localparam logic signed [16:0] Q12_HALF_PI = 17'sd6434;
  localparam logic signed [16:0] Q12_TWO_PI  = 17'sd25736;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;

  localparam logic [31:0] ATAN_Q30 [16] = '{
    32'd843314857, 32'd497837830, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388438,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768
  };

endpackage
`default_nettype wire

// ===== hdl/wpt_chan_if.sv =====
// Valid/ready channels of the waypoint path tracker: command in, track result out.
// Plain signal bundles; no package dependency.
`default_nettype none
interface wpt_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic        [9:0]  point_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;
  logic signed [31:0] curvature;
  logic signed [31:0] speed;
  logic        [31:0] arc_length;

  modport source (output valid, cmd, point_index, pos_x, pos_y, heading, curvature,
                  speed, arc_length, input ready);
  modport sink (input valid, cmd, point_index, pos_x, pos_y, heading, curvature,
                speed, arc_length, output ready);
endinterface

interface wpt_out_if;
  logic               valid;
  logic               ready;
  logic        [9:0]  closest_index;
  logic        [9:0]  lookahead_index;
  logic signed [31:0] cross_track_error;
  logic               path_complete;
  logic signed [31:0] ref_x;
  logic signed [31:0] ref_y;
  logic signed [15:0] ref_heading;
  logic signed [31:0] ref_curvature;
  logic signed [31:0] ref_speed;
  logic        [31:0] ref_arc;

  modport source (output valid, closest_index, lookahead_index, cross_track_error,
                  path_complete, ref_x, ref_y, ref_heading, ref_curvature, ref_speed,
                  ref_arc, input ready);
  modport sink (input valid, closest_index, lookahead_index, cross_track_error,
                path_complete, ref_x, ref_y, ref_heading, ref_curvature, ref_speed,
                ref_arc, output ready);
endinterface
`default_nettype wire

// ===== hdl/wpt_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module wpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== hdl/waypoint_path_tracker_unit.sv =====
// Waypoint path tracker top level: waypoint memory, distance pipeline, sqrt, CORDIC, sequencer.
// Depends on wpt_pkg, wpt_chan_if (wpt_in_if, wpt_out_if) and wpt_ram.
//
// Waypoints live in one MAX_POINTS-deep RAM and every step goes through its single read
// port, so one transaction is worked on at a time. A load is written directly, or, when
// arc lengths are generated, goes through the 3-stage distance pipeline, a 32-step square
// root and the write. A track transaction reads the search window entries through the
// distance pipeline, one read per cycle, drains it, reads the best point, runs the CORDIC
// sine/cosine and the cross-track product, then walks the lookahead points with a read and
// a compare per point. An empty path answers with an all-zero result. The result register
// lets the next transaction in while a result waits to be taken; the output state holds
// until that register is free.
`default_nettype none
module waypoint_path_tracker_unit #(
  parameter int MAX_POINTS    = 1024,
  parameter int SEARCH_WINDOW = 50
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  wpt_in_if.sink           req_i,
  wpt_out_if.source        rsp_o
);
  import wpt_pkg::*;

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int SWW = $clog2(SEARCH_WINDOW + 1);
  localparam int EW  = ((CW > SWW) ? CW : SWW) + 1;
  localparam int IW  = ((CW > 10) ? CW : 10) + 1;
  localparam int RW  = $bits(waypoint_t);

  wpt_state_e state_q, state_d;

  logic [31:0] la_q, thr_q;
  logic [CW-1:0] count_q;
  logic [AW-1:0] tracked_q;
  logic          auto_q;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  waypoint_t      ram_wdata, rd;
  logic [RW-1:0]  ram_rdata;

  wpt_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );
  assign rd = waypoint_t'(ram_rdata);

  // config port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr)
      REG_LOOKAHEAD: prdata = la_q;
      REG_DONE_THR:  prdata = thr_q;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      la_q  <= LOOKAHEAD_RST;
      thr_q <= DONE_THR_RST;
    end else if (cfg_wr) begin
      unique case (paddr)
        REG_LOOKAHEAD: la_q  <= pwdata;
        REG_DONE_THR:  thr_q <= pwdata;
        default: ;
      endcase
    end
  end

  // input decode
  logic          in_acc, is_load, is_zero, ld_ok, ld_auto, ld_direct;
  logic [IW-1:0] pi_ext, cnt_eff;
  assign in_acc  = req_i.valid && req_i.ready;
  assign is_load = (req_i.cmd == CMD_LOAD);
  assign is_zero = (req_i.point_index == 10'd0);
  assign pi_ext  = IW'(req_i.point_index);
  assign cnt_eff = is_zero ? '0 : IW'(count_q);
  assign ld_ok   = (pi_ext == cnt_eff) && (pi_ext < IW'(MAX_POINTS));
  assign ld_auto = is_zero ? (req_i.arc_length == 32'd0) : auto_q;
  assign ld_direct = in_acc && is_load && ld_ok && (is_zero || !ld_auto);

  // track window
  logic [AW-1:0] start_idx;
  logic [EW-1:0] win_sum, win_end;
  assign start_idx = (AW'(tracked_q) < AW'(count_q - 1'b1)) || (CW'(tracked_q) < count_q)
                     ? tracked_q : AW'(count_q - 1'b1);
  assign win_sum = EW'(start_idx) + EW'(SEARCH_WINDOW);
  assign win_end = (win_sum > EW'(count_q)) ? EW'(count_q) : win_sum;

  // payload registers
  waypoint_t           ld_q;
  logic [AW-1:0]       ld_addr_q;
  logic signed [31:0]  prev_x_q, prev_y_q;
  logic [31:0]         prev_arc_q;
  logic signed [31:0]  px_q, py_q;
  logic [EW-1:0]       ptr_q, end_q;
  logic                rv_q;
  logic [AW-1:0]       ridx_q;

  // shared distance pipeline
  logic                v0, v1_q, v2_q;
  logic [AW-1:0]       idx1_q, idx2_q;
  logic signed [32:0]  dxa, dya;
  logic [32:0]         a1_q, b1_q;
  logic [65:0]         a2_q, b2_q, dsum;
  logic signed [31:0]  op_x0, op_x1, op_y0, op_y1;

  always_comb begin
    if (state_q == ST_LD_SQ) begin
      op_x0 = ld_q.x;
      op_x1 = prev_x_q;
      op_y0 = ld_q.y;
      op_y1 = prev_y_q;
      v0    = 1'b1;
    end else begin
      op_x0 = px_q;
      op_x1 = rd.x;
      op_y0 = py_q;
      op_y1 = rd.y;
      v0    = rv_q;
    end
  end
  assign dxa  = 33'(op_x0) - 33'(op_x1);
  assign dya  = 33'(op_y0) - 33'(op_y1);
  assign dsum = a2_q + b2_q;

  logic [65:0]   best_sum_q;
  logic          best_v_q;
  logic [AW-1:0] best_q;
  logic          searching;
  assign searching = (state_q == ST_SRCH) || (state_q == ST_DRAIN);

  // square root
  logic [63:0] rad_q;
  logic [31:0] root_q;
  logic [34:0] rem_q, rem_t, trial;
  logic        sat_q;
  logic [4:0]  it_q;
  logic [32:0] arc_new;
  logic [31:0] ds;
  assign rem_t   = {rem_q[32:0], rad_q[63:62]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign ds      = sat_q ? 32'hFFFF_FFFF : root_q;
  assign arc_new = 33'(prev_arc_q) + 33'(ds);

  // cross-track
  logic signed [32:0] dx_q, dy_q;
  logic signed [16:0] th0, th1, th2;
  logic               fold;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic               neg_q;
  logic [3:0]         ci_q;
  logic signed [33:0] cxs, cys, atn, xcl, ycl;
  logic signed [31:0] sn, cs;
  logic signed [64:0] ps_q, pc_q;
  logic signed [35:0] cte_full;
  logic signed [31:0] cte_q;

  assign th0 = 17'(rd.heading);
  always_comb begin
    if (th0 > Q12_PI) begin
      th1 = th0 - Q12_TWO_PI;
    end else if (th0 < -Q12_PI) begin
      th1 = th0 + Q12_TWO_PI;
    end else begin
      th1 = th0;
    end
    fold = 1'b0;
    th2  = th1;
    if (th1 > Q12_HALF_PI) begin
      th2  = th1 - Q12_PI;
      fold = 1'b1;
    end else if (th1 < -Q12_HALF_PI) begin
      th2  = th1 + Q12_PI;
      fold = 1'b1;
    end
  end

  assign cxs = cx_q >>> ci_q;
  assign cys = cy_q >>> ci_q;
  assign atn = 34'(ATAN_Q30[ci_q]);
  assign xcl = (cx_q > Q30_ONE) ? Q30_ONE : ((cx_q < -Q30_ONE) ? -Q30_ONE : cx_q);
  assign ycl = (cy_q > Q30_ONE) ? Q30_ONE : ((cy_q < -Q30_ONE) ? -Q30_ONE : cy_q);
  assign cs  = neg_q ? 32'(-xcl) : 32'(xcl);
  assign sn  = neg_q ? 32'(-ycl) : 32'(ycl);
  assign cte_full = 36'(ps_q >>> 30) - 36'(pc_q >>> 30);

  // lookahead and completion
  logic [32:0]   target_q, min_q, la_diff;
  logic [CW-1:0] la_ptr_q;
  logic [AW-1:0] look_q;
  logic          done_q;
  logic signed [33:0] rem_arc;
  logic [CW-1:0] tail_idx;
  assign la_diff  = (33'(rd.arc) > target_q) ? 33'(rd.arc) - target_q
                                             : target_q - 33'(rd.arc);
  assign tail_idx = count_q - 1'b1;
  assign rem_arc  = 34'(prev_arc_q) - 34'(rd.arc);

  // output register
  logic out_v_q, slot_free;
  assign slot_free = !out_v_q || rsp_o.ready;
  assign rsp_o.valid = out_v_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!is_load) begin
            state_d = (count_q == '0) ? ST_EMPTY : ST_SRCH;
          end else if (ld_ok && ld_auto && !is_zero) begin
            state_d = ST_LD_SQ;
          end
        end
      end
      ST_LD_SQ:   state_d = ST_LD_WAIT;
      ST_LD_WAIT: if (v2_q) state_d = ST_LD_ROOT;
      ST_LD_ROOT: if (it_q == 5'd31) state_d = ST_LD_WR;
      ST_LD_WR:   state_d = ST_IDLE;
      ST_SRCH:    if (ptr_q == end_q - 1'b1) state_d = ST_DRAIN;
      ST_DRAIN:   if (!rv_q && !v1_q && !v2_q) state_d = ST_RD_BEST;
      ST_RD_BEST: state_d = ST_CTE_CAP;
      ST_CTE_CAP: state_d = ST_CORDIC;
      ST_CORDIC:  if (ci_q == 4'd15) state_d = ST_MUL;
      ST_MUL:     state_d = ST_CTE_SUM;
      ST_CTE_SUM: state_d = ST_LA_RD;
      ST_LA_RD:   state_d = (la_ptr_q >= count_q) ? ST_RD_LOOK : ST_LA_CMP;
      ST_LA_CMP:  state_d = (la_diff < min_q) ? ST_LA_RD : ST_RD_LOOK;
      ST_RD_LOOK: state_d = ST_OUT;
      ST_OUT:     if (slot_free) state_d = ST_IDLE;
      ST_EMPTY:   if (slot_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_i.ready = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = ld_addr_q;
    ram_wdata   = ld_q;
    ram_re      = 1'b0;
    ram_raddr   = AW'(ptr_q);
    unique case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        ram_we      = ld_direct;
        ram_waddr   = AW'(req_i.point_index);
        ram_wdata   = '{x: req_i.pos_x, y: req_i.pos_y, heading: req_i.heading,
                        curvature: req_i.curvature, speed: req_i.speed,
                        arc: req_i.arc_length};
      end
      ST_LD_WR: begin
        ram_we        = 1'b1;
        ram_wdata.arc = arc_new[32] ? 32'hFFFF_FFFF : arc_new[31:0];
      end
      ST_SRCH: ram_re = 1'b1;
      ST_RD_BEST: begin
        ram_re    = 1'b1;
        ram_raddr = best_q;
      end
      ST_LA_RD: begin
        ram_re    = (la_ptr_q < count_q);
        ram_raddr = AW'(la_ptr_q);
      end
      ST_RD_LOOK: begin
        ram_re    = 1'b1;
        ram_raddr = look_q;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      tracked_q <= '0;
      auto_q    <= 1'b0;
      rv_q      <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      best_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= (state_q == ST_SRCH);
      v1_q    <= v0;
      v2_q    <= v1_q;
      // a point 0 load is always written directly, so the count restarts at one
      if (in_acc && is_load && is_zero) begin
        tracked_q <= '0;
        auto_q    <= ld_auto;
      end
      if (ld_direct) begin
        count_q <= CW'(pi_ext + 1'b1);
      end else if (state_q == ST_LD_WR) begin
        count_q <= CW'(ld_addr_q) + 1'b1;
      end
      if (state_q == ST_IDLE) begin
        best_v_q <= 1'b0;
      end else if (searching && v2_q) begin
        best_v_q <= 1'b1;
      end
      if (state_q == ST_RD_BEST) begin
        tracked_q <= best_q;
      end
      if ((state_q == ST_OUT || state_q == ST_EMPTY) && slot_free) begin
        out_v_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    a1_q   <= 33'(dxa < 0 ? -dxa : dxa);
    b1_q   <= 33'(dya < 0 ? -dya : dya);
    idx1_q <= ridx_q;
    a2_q   <= 66'(a1_q) * 66'(a1_q);
    b2_q   <= 66'(b1_q) * 66'(b1_q);
    idx2_q <= idx1_q;
    ridx_q <= AW'(ptr_q);

    if (in_acc) begin
      ld_q      <= '{x: req_i.pos_x, y: req_i.pos_y, heading: req_i.heading,
                     curvature: req_i.curvature, speed: req_i.speed,
                     arc: req_i.arc_length};
      ld_addr_q <= AW'(req_i.point_index);
      px_q      <= req_i.pos_x;
      py_q      <= req_i.pos_y;
      ptr_q     <= EW'(start_idx);
      end_q     <= win_end;
    end
    if (ld_direct) begin
      prev_x_q   <= req_i.pos_x;
      prev_y_q   <= req_i.pos_y;
      prev_arc_q <= req_i.arc_length;
    end
    if (state_q == ST_LD_WR) begin
      prev_x_q   <= ld_q.x;
      prev_y_q   <= ld_q.y;
      prev_arc_q <= arc_new[32] ? 32'hFFFF_FFFF : arc_new[31:0];
    end
    if (state_q == ST_SRCH) begin
      ptr_q <= ptr_q + 1'b1;
    end

    if (searching && v2_q && (!best_v_q || dsum < best_sum_q)) begin
      best_sum_q <= dsum;
      best_q     <= idx2_q;
    end

    if (state_q == ST_LD_WAIT && v2_q) begin
      sat_q  <= (dsum[65:64] != 2'b00);
      rad_q  <= dsum[63:0];
      root_q <= '0;
      rem_q  <= '0;
      it_q   <= '0;
    end
    if (state_q == ST_LD_ROOT) begin
      it_q  <= it_q + 1'b1;
      rad_q <= {rad_q[61:0], 2'b00};
      if (rem_t >= trial) begin
        rem_q  <= rem_t - trial;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= rem_t;
        root_q <= {root_q[30:0], 1'b0};
      end
    end

    if (state_q == ST_CTE_CAP) begin
      dx_q       <= 33'(px_q) - 33'(rd.x);
      dy_q       <= 33'(py_q) - 33'(rd.y);
      cx_q       <= CORDIC_GAIN;
      cy_q       <= '0;
      cz_q       <= 34'(th2) <<< 18;
      neg_q      <= fold;
      ci_q       <= '0;
      target_q   <= 33'(rd.arc) + 33'(la_q);
      min_q      <= 33'(la_q);
      look_q     <= best_q;
      la_ptr_q   <= CW'(best_q) + 1'b1;
      done_q     <= (CW'(best_q) >= tail_idx) || (rem_arc < $signed(34'(thr_q)));
    end
    if (state_q == ST_CORDIC) begin
      ci_q <= ci_q + 1'b1;
      if (cz_q >= 0) begin
        cx_q <= cx_q - cys;
        cy_q <= cy_q + cxs;
        cz_q <= cz_q - atn;
      end else begin
        cx_q <= cx_q + cys;
        cy_q <= cy_q - cxs;
        cz_q <= cz_q + atn;
      end
    end
    if (state_q == ST_MUL) begin
      ps_q <= 65'(sn) * 65'(dx_q);
      pc_q <= 65'(cs) * 65'(dy_q);
    end
    if (state_q == ST_CTE_SUM) begin
      if (cte_full > 36'sd2147483647) begin
        cte_q <= 32'sh7FFF_FFFF;
      end else if (cte_full < -36'sd2147483648) begin
        cte_q <= 32'sh8000_0000;
      end else begin
        cte_q <= 32'(cte_full);
      end
    end
    if (state_q == ST_LA_CMP && la_diff < min_q) begin
      min_q    <= la_diff;
      look_q   <= AW'(la_ptr_q);
      la_ptr_q <= la_ptr_q + 1'b1;
    end

    if (state_q == ST_OUT && slot_free) begin
      rsp_o.closest_index     <= 10'(best_q);
      rsp_o.lookahead_index   <= 10'(look_q);
      rsp_o.cross_track_error <= cte_q;
      rsp_o.path_complete     <= done_q;
      rsp_o.ref_x             <= rd.x;
      rsp_o.ref_y             <= rd.y;
      rsp_o.ref_heading       <= rd.heading;
      rsp_o.ref_curvature     <= rd.curvature;
      rsp_o.ref_speed         <= rd.speed;
      rsp_o.ref_arc           <= rd.arc;
    end else if (state_q == ST_EMPTY && slot_free) begin
      rsp_o.closest_index     <= '0;
      rsp_o.lookahead_index   <= '0;
      rsp_o.cross_track_error <= '0;
      rsp_o.path_complete     <= 1'b0;
      rsp_o.ref_x             <= '0;
      rsp_o.ref_y             <= '0;
      rsp_o.ref_heading       <= '0;
      rsp_o.ref_curvature     <= '0;
      rsp_o.ref_speed         <= '0;
      rsp_o.ref_arc           <= '0;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_POINTS))
    else $error("point count beyond memory depth");

  a_tracked_in_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (CW'(tracked_q) < count_q))
    else $error("tracked index outside loaded path");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> ($past(state_q) == ST_OUT || $past(state_q) == ST_EMPTY))
    else $error("result raised outside output states");

  a_search_in_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH) |-> (ptr_q < EW'(count_q)))
    else $error("search read beyond loaded path");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/waypoint_path_tracker_unit_tb.sv =====
// Self-checking testbench for waypoint_path_tracker_unit: loads, tracking and register sweeps.
// Uses wpt_pkg and the wpt_in_if / wpt_out_if channels; an internal predictor checks results.
`timescale 1ns / 1ps
module waypoint_path_tracker_unit_tb;
  import wpt_pkg::*;

  localparam int NPTS   = 1024;
  localparam int WINDOW = 50;

  typedef struct {
    wpt_cmd_e           cmd;
    logic        [9:0]  idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] hdg;
    logic signed [31:0] curv;
    logic signed [31:0] spd;
    logic        [31:0] arc;
  } cmd_item_t;

  typedef struct {
    logic        [9:0]  closest;
    logic        [9:0]  look;
    logic signed [31:0] cte;
    logic               done;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [15:0] rhdg;
    logic signed [31:0] rcurv;
    logic signed [31:0] rspd;
    logic        [31:0] rarc;
  } track_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  wpt_in_if  req ();
  wpt_out_if rsp ();

  waypoint_path_tracker_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_i(req), .rsp_o(rsp)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [31:0] wp_x [NPTS];
  logic [31:0] wp_y [NPTS];
  logic [15:0] wp_hdg [NPTS];
  logic [31:0] wp_curv [NPTS];
  logic [31:0] wp_spd [NPTS];
  logic [31:0] wp_arc [NPTS];
  logic [9:0]  trk_idx = '0;
  logic [10:0] n_points = '0;
  logic        arc_gen = 1'b0;
  logic [31:0] la_dist = LOOKAHEAD_RST;
  logic [31:0] done_thr = DONE_THR_RST;

  track_result_t expected_q[$];
  int fail_count = 0;
  int n_items = 0, n_results = 0, n_paths = 0;
  bit idle_on = 1'b1;
  int rx_hold = 0;

  function automatic logic [31:0] isqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  function automatic logic [63:0] sq_dist(longint a, longint b, output bit ovf);
    logic [63:0] ua, ub, a2, s;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    a2 = ua * ua;
    s = a2 + ub * ub;
    ovf = s < a2;
    return s;
  endfunction

  function automatic void sin_cos(longint th, output longint sn, output longint cs);
    longint x, y, z, nx;
    bit neg;
    x = 652032874;
    y = 0;
    neg = 0;
    while (th > 12868) th -= 25736;
    while (th < -12868) th += 25736;
    if (th > 6434) begin
      th -= 12868;
      neg = 1;
    end else if (th < -6434) begin
      th += 12868;
      neg = 1;
    end
    z = th * 262144;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(ATAN_Q30[i]);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += longint'(ATAN_Q30[i]);
      end
      x = nx;
    end
    if (x > 64'sd1073741824) x = 1073741824;
    if (x < -64'sd1073741824) x = -1073741824;
    if (y > 64'sd1073741824) y = 1073741824;
    if (y < -64'sd1073741824) y = -1073741824;
    cs = neg ? -x : x;
    sn = neg ? -y : y;
  endfunction

  function automatic void store_waypoint(cmd_item_t it);
    int i;
    bit ovf;
    logic [63:0] s, ds, a;
    i = it.idx;
    if (i == 0) begin
      n_points = 0;
      trk_idx = 0;
      arc_gen = (it.arc == 0);
    end
    if (i != n_points) return;
    wp_x[i] = it.x; wp_y[i] = it.y; wp_hdg[i] = it.hdg;
    wp_curv[i] = it.curv; wp_spd[i] = it.spd; wp_arc[i] = it.arc;
    if (arc_gen && i > 0) begin
      s = sq_dist(longint'($signed(wp_x[i])) - longint'($signed(wp_x[i-1])),
                  longint'($signed(wp_y[i])) - longint'($signed(wp_y[i-1])), ovf);
      ds = ovf ? 64'hFFFF_FFFF : {32'd0, isqrt(s)};
      a = {32'd0, wp_arc[i-1]} + ds;
      wp_arc[i] = (a > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : a[31:0];
    end
    n_points = 11'(i + 1);
  endfunction

  function automatic track_result_t track_vehicle(cmd_item_t it);
    track_result_t r;
    int st, en, best, lk, last;
    logic [63:0] blo, lo, tgt, mind, arcv, diff;
    bit bhi, ovf, dn;
    longint px, py, dx, dy, sn, cs, cte;
    r = '{default: '0};
    if (n_points == 0) return r;
    px = it.x;
    py = it.y;
    st = (trk_idx < n_points) ? trk_idx : n_points - 1;
    en = st + WINDOW;
    if (en > n_points) en = n_points;
    best = st;
    bhi = 1;
    blo = '1;
    for (int i = st; i < en; i++) begin
      lo = sq_dist(px - $signed(wp_x[i]), py - $signed(wp_y[i]), ovf);
      if (i == st || ovf < bhi || (ovf == bhi && lo < blo)) begin
        bhi = ovf; blo = lo; best = i;
      end
    end
    trk_idx = 10'(best);
    dx = px - longint'($signed(wp_x[best]));
    dy = py - longint'($signed(wp_y[best]));
    sin_cos(longint'($signed(wp_hdg[best])), sn, cs);
    cte = ((sn * dx) >>> 30) - ((cs * dy) >>> 30);
    if (cte > 64'sd2147483647) cte = 2147483647;
    if (cte < -64'sd2147483648) cte = -2147483648;
    tgt = {32'd0, wp_arc[best]} + {32'd0, la_dist};
    mind = {32'd0, la_dist};
    lk = best;
    for (int i = best + 1; i < n_points; i++) begin
      arcv = {32'd0, wp_arc[i]};
      diff = (arcv > tgt) ? arcv - tgt : tgt - arcv;
      if (diff < mind) begin
        mind = diff; lk = i;
      end else break;
    end
    last = n_points - 1;
    if (best >= last) dn = 1;
    else dn = (longint'(wp_arc[last]) - longint'(wp_arc[best])) < longint'(done_thr);
    r.closest = 10'(best); r.look = 10'(lk); r.cte = cte[31:0]; r.done = dn;
    r.rx = wp_x[lk]; r.ry = wp_y[lk]; r.rhdg = wp_hdg[lk];
    r.rcurv = wp_curv[lk]; r.rspd = wp_spd[lk]; r.rarc = wp_arc[lk];
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h actual %0h", name, e, a);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    track_result_t e;
    if (rst_ni && rsp.valid && rsp.ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result transaction with no expectation pending");
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        check_field("closest_index", e.closest, rsp.closest_index);
        check_field("lookahead_index", e.look, rsp.lookahead_index);
        check_field("cross_track_error", e.cte, rsp.cross_track_error);
        check_field("path_complete", e.done, rsp.path_complete);
        check_field("ref_x", e.rx, rsp.ref_x);
        check_field("ref_y", e.ry, rsp.ref_y);
        check_field("ref_heading", e.rhdg, rsp.ref_heading);
        check_field("ref_curvature", e.rcurv, rsp.ref_curvature);
        check_field("ref_speed", e.rspd, rsp.ref_speed);
        check_field("ref_arc", e.rarc, rsp.ref_arc);
      end
    end
  end

  // receiver: random gaps and random long hold-offs, plus long hold-offs on request
  initial begin
    int r;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        rsp.ready = 1'b0;
        rx_hold--;
      end else if (!idle_on) begin
        rsp.ready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r == 0) rx_hold = $urandom_range(10, 60);
        rsp.ready = (r >= 30);
      end
    end
  end

  function automatic int gap_len();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(cmd_item_t it);
    int g;
    req.valid = 1'b1;
    req.cmd = it.cmd; req.point_index = it.idx; req.pos_x = it.x; req.pos_y = it.y;
    req.heading = it.hdg; req.curvature = it.curv; req.speed = it.spd;
    req.arc_length = it.arc;
    do @(posedge clk_i); while (!req.ready);
    n_items++;
    if (it.cmd == CMD_LOAD) store_waypoint(it);
    else expected_q.push_back(track_vehicle(it));
    @(negedge clk_i);
    g = gap_len();
    if (g > 0) begin
      req.valid = 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    req.valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] val);
    wait_idle();
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == REG_LOOKAHEAD) la_dist = val;
    else done_thr = val;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic apb_check(logic [2:0] addr, logic [31:0] val);
    psel = 1'b1; pwrite = 1'b0; penable = 1'b0; paddr = addr;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("prdata", val, prdata);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
  endtask

  function automatic cmd_item_t mk_load(int i, longint x, longint y, logic [31:0] arc);
    cmd_item_t it;
    it.cmd = CMD_LOAD; it.idx = 10'(i); it.x = 32'(x); it.y = 32'(y);
    it.hdg = 16'($urandom); it.curv = $urandom; it.spd = $urandom; it.arc = arc;
    return it;
  endfunction

  function automatic cmd_item_t mk_track(longint x, longint y);
    cmd_item_t it;
    it.cmd = CMD_TRACK; it.idx = 10'($urandom); it.x = 32'(x); it.y = 32'(y);
    it.hdg = 16'($urandom); it.curv = $urandom; it.spd = $urandom; it.arc = $urandom;
    return it;
  endfunction

  // path of n points; arc generation when gen is set, else increasing given arcs
  task automatic load_path(int n, bit gen);
    longint x, y;
    logic [31:0] arc;
    x = $signed(32'($urandom)) >>> $urandom_range(2, 12);
    y = $signed(32'($urandom)) >>> $urandom_range(2, 12);
    arc = gen ? 32'd0 : 32'($urandom_range(0, 1 << 20));
    n_paths++;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(mk_load($urandom_range(n_points + 1, 1023), $urandom, $urandom, $urandom));
      send_item(mk_load(i, x, y, arc));
      x += $urandom_range(0, 3 << 16) - (1 << 16);
      y += $urandom_range(0, 3 << 16) - (1 << 16);
      arc += $urandom_range(1, 3 << 16);
    end
  endtask

  task automatic track_along(int n);
    int k;
    longint nx, ny;
    k = trk_idx;
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(mk_track($urandom, $urandom));
      end else begin
        k = k + $urandom_range(0, 3);
        if (k >= n_points) k = n_points - 1;
        nx = $urandom_range(0, 1 << 16) - (1 << 15);
        ny = $urandom_range(0, 1 << 16) - (1 << 15);
        send_item(mk_track($signed(wp_x[k]) + nx, $signed(wp_y[k]) + ny));
      end
    end
  endtask

  task automatic test_empty_path();
    send_item(mk_track(0, 0));
    send_item(mk_track(32'sh7FFF_FFFF, 32'sh8000_0000));
  endtask

  task automatic test_extremes();
    cmd_item_t it;
    // arc generation with a step too long to square
    it = mk_load(0, 32'sh8000_0000, 32'sh8000_0000, 0);
    it.hdg = 16'sh8000;
    send_item(it);
    it = mk_load(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
    it.hdg = 16'sh7FFF;
    send_item(it);
    send_item(mk_load(2, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF));
    send_item(mk_load(9, 0, 0, 0));
    send_item(mk_load(1023, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF));
    send_item(mk_track(32'sh7FFF_FFFF, 32'sh8000_0000));
    send_item(mk_track(32'sh8000_0000, 32'sh7FFF_FFFF));
    send_item(mk_track(32'sh8000_0000, 32'sh8000_0000));
    // given arcs, single-point path
    send_item(mk_load(0, 0, 0, 32'hFFFF_FFFF));
    send_item(mk_track(32'sh7FFF_FFFF, 0));
    send_item(mk_track(0, -1));
    load_path(6, 1'b1);
    track_along(6);
  endtask

  task automatic test_registers();
    apb_write(REG_LOOKAHEAD, 32'hFFFF_FFFF);
    apb_write(REG_DONE_THR, 32'hFFFF_FFFF);
    apb_check(REG_LOOKAHEAD, 32'hFFFF_FFFF);
    apb_check(REG_DONE_THR, 32'hFFFF_FFFF);
    load_path(20, 1'b0);
    track_along(5);
    apb_write(REG_LOOKAHEAD, 32'd0);
    apb_write(REG_DONE_THR, 32'd0);
    track_along(5);
  endtask

  task automatic test_backpressure();
    load_path(30, 1'b1);
    wait_idle();
    rx_hold = 400;
    track_along(20);
    wait_idle();
  endtask

  task automatic test_random();
    logic [31:0] v;
    while (n_items < 950) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0: v = 0;
          1: v = 32'hFFFF_FFFF;
          2: v = $urandom;
          default: v = $urandom_range(0, 10 << 16);
        endcase
        apb_write($urandom_range(0, 1) ? REG_LOOKAHEAD : REG_DONE_THR, v);
      end
      idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 39) == 0) load_path($urandom_range(100, 300), 1'b0);
      else load_path($urandom_range(2, 40), $urandom_range(0, 1));
      track_along($urandom_range(5, 25));
    end
    idle_on = 1'b1;
  endtask

  initial begin
    req.valid = 1'b0; req.cmd = CMD_LOAD; req.point_index = '0;
    req.pos_x = '0; req.pos_y = '0; req.heading = '0; req.curvature = '0;
    req.speed = '0; req.arc_length = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_empty_path();
    test_extremes();
    test_registers();
    test_backpressure();
    test_random();
    wait_idle();
    $display("covered %0d input transactions over %0d paths, %0d results checked",
             n_items, n_paths, n_results);
    $display("register sweeps, hold-offs and arc generation overflow included");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule

// ===== waypoint_path_tracker_unit.f =====
hdl/wpt_pkg.sv
hdl/wpt_chan_if.sv
hdl/wpt_ram.sv
hdl/waypoint_path_tracker_unit.sv
tb/sv/waypoint_path_tracker_unit_tb.sv
